FILE: hw/rtl/cms_pkg.sv
// Package for the cave map smoothing block: payload structs, the column-count
// state code and the stage status struct shared by the RTL modules.
// Depends on nothing.
package cms_pkg;

  // Width of one map column on the ports.
  localparam int unsigned COL_W = 64;
  // Width of the height register.
  localparam int unsigned HEIGHT_W = 7;
  // Height after reset.
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd10;

  // One input column.
  typedef struct packed {
    logic [COL_W-1:0] column_cells;
    logic             last_column;
  } in_item_t;

  // One smoothed column.
  typedef struct packed {
    logic [COL_W-1:0] smoothed_cells;
    logic             last_of_run;
    logic             end_of_map;
  } out_item_t;

  // How many columns of the current map have been seen.
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_ONE  = 2'd1,
    HELD_MANY = 2'd2
  } held_t;

  // Status of the result waiting in the window stage.
  typedef struct packed {
    logic valid;
    logic last_of_run;
    logic end_of_map;
  } stage_status_t;

endpackage

FILE: hw/rtl/cms_stream_if.sv
// Valid/ready stream interface that carries one payload per transfer.
// Depends on cms_pkg for the payload types used by its instances.
interface cms_stream_if #(
  parameter type T = cms_pkg::in_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cave_map_smoothing.sv
// Cave map smoothing, one 4-5 cellular automaton pass over columns.
// After the transfer of the column that completes its window, a column's result
// passes through the window stage and then the result register before it leaves.
// Throughput: one column per cycle unless the output stalls; a map's final column
// holds input for its second result. Reset clears history, stage and height to 10.
// Depends on cms_pkg, cms_stream_if, cms_window and cms_cell_rule.
module cave_map_smoothing #(
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cms_pkg::HEIGHT_W-1:0]      cfg_wdata,
  cms_stream_if.sink                        column_in,
  cms_stream_if.source                      column_out
);

  localparam int unsigned W = MAX_HEIGHT;

  logic [cms_pkg::HEIGHT_W-1:0] map_height;
  logic [cms_pkg::HEIGHT_W-1:0] eff_height;
  logic [W-1:0]                 mask;

  logic [W-1:0]                 win_left;
  logic [W-1:0]                 win_mid;
  logic [W-1:0]                 win_right;
  logic [W-1:0]                 rule_cells;
  cms_pkg::stage_status_t       status;
  logic                         take;

  logic                         out_valid;
  logic                         out_valid_next;
  cms_pkg::out_item_t           out_data;

  // Height register.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_height <= cms_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      map_height <= cfg_wdata;
    end
  end

  // Height of zero acts as one, anything above the column width acts as the width.
  always_comb begin
    if (map_height == '0) begin
      eff_height = cms_pkg::HEIGHT_W'(1);
    end else if (map_height > cms_pkg::HEIGHT_W'(MAX_HEIGHT)) begin
      eff_height = cms_pkg::HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_height = map_height;
    end
  end

  // Rows in use.
  for (genvar k = 0; k < W; k++) begin : g_mask
    assign mask[k] = cms_pkg::HEIGHT_W'(k) < eff_height;
  end

  cms_window #(
    .W (W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .mask      (mask),
    .in_valid  (column_in.valid),
    .in_ready  (column_in.ready),
    .in_cells  (column_in.data.column_cells[W-1:0]),
    .in_last   (column_in.data.last_column),
    .take      (take),
    .win_left  (win_left),
    .win_mid   (win_mid),
    .win_right (win_right),
    .status    (status)
  );

  cms_cell_rule #(
    .W (W)
  ) u_rule (
    .left  (win_left),
    .mid   (win_mid),
    .right (win_right),
    .cells (rule_cells)
  );

  // A pending result moves into the output register when that register is free.
  assign take           = status.valid && (!out_valid || column_out.ready);
  assign out_valid_next = take || (out_valid && !column_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_data.smoothed_cells <= cms_pkg::COL_W'(rule_cells & mask);
      out_data.last_of_run    <= status.last_of_run;
      out_data.end_of_map     <= status.end_of_map;
    end
  end

  assign column_out.valid = out_valid;
  assign column_out.data  = out_data;

`ifndef SYNTHESIS
  // The map's final column always closes the run of its input.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    column_out.valid && column_out.data.end_of_map |-> column_out.data.last_of_run)
    else $error("end_of_map result without last_of_run");

  // Rows above the height never leave the block set.
  a_unused_rows_zero: assert property (@(posedge clk) disable iff (rst)
    column_out.valid |->
      ((column_out.data.smoothed_cells & ~cms_pkg::COL_W'(mask)) == '0))
    else $error("smoothed column has bits above the height");

  // Input back-pressure only comes from a pending result.
  a_ready_low_means_pending: assert property (@(posedge clk) disable iff (rst)
    !column_in.ready |-> status.valid)
    else $error("input stalled with an empty window stage");

  // A result that does not close its run is followed by the second one.
  a_second_result_follows: assert property (@(posedge clk) disable iff (rst)
    take && !status.last_of_run |=> status.valid && status.end_of_map)
    else $error("second result of the final column lost");
`endif

endmodule

FILE: hw/rtl/cms_cell_rule.sv
// Neighbor count and 4-5 rule for every row of one column window.
// Depends on nothing; inputs carry wall in all rows at or above the height.
module cms_cell_rule #(
  parameter int unsigned W = 64
) (
  input  logic [W-1:0] left,
  input  logic [W-1:0] mid,
  input  logic [W-1:0] right,
  output logic [W-1:0] cells
);

  // Rows below row 0 and above the top row count as wall.
  logic [W+1:0] left_ext;
  logic [W+1:0] mid_ext;
  logic [W+1:0] right_ext;

  assign left_ext  = {1'b1, left, 1'b1};
  assign mid_ext   = {1'b1, mid, 1'b1};
  assign right_ext = {1'b1, right, 1'b1};

  // Each row counts its eight neighbors independently.
  for (genvar k = 0; k < W; k++) begin : g_row
    logic [3:0] count;

    assign count = 4'(left_ext[k]) + 4'(left_ext[k+1]) + 4'(left_ext[k+2])
                 + 4'(right_ext[k]) + 4'(right_ext[k+1]) + 4'(right_ext[k+2])
                 + 4'(mid_ext[k]) + 4'(mid_ext[k+2]);

    // More than four walls makes wall, exactly four keeps the old cell.
    assign cells[k] = (count > 4'd4) || ((count == 4'd4) && mid_ext[k+1]);
  end

endmodule

FILE: hw/rtl/cms_window.sv
// Column history and window stage: takes input columns, tracks the map
// position and holds up to two pending results. Depends on cms_pkg.
module cms_window #(
  parameter int unsigned W = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [W-1:0]          mask,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [W-1:0]          in_cells,
  input  logic                  in_last,
  input  logic                  take,
  output logic [W-1:0]          win_left,
  output logic [W-1:0]          win_mid,
  output logic [W-1:0]          win_right,
  output cms_pkg::stage_status_t status
);

  localparam logic [W-1:0] WALL = '1;

  cms_pkg::held_t held;
  cms_pkg::held_t held_next;
  logic [W-1:0]   prev_col;
  logic [W-1:0]   prev_col_next;
  logic [W-1:0]   older_col;
  logic [W-1:0]   older_col_next;

  // Window of padded columns; the fourth column is always wall.
  logic [W-1:0]   w0;
  logic [W-1:0]   w1;
  logic [W-1:0]   w2;
  logic [W-1:0]   w0_next;
  logic [W-1:0]   w1_next;
  logic [W-1:0]   w2_next;
  logic           pend1;
  logic           pend2;
  logic           pend1_next;
  logic           pend2_next;

  logic           accept;
  logic           drains;
  logic [W-1:0]   col_masked;

  // The stage frees up when its only remaining result moves on.
  assign drains   = take && !(pend1 && pend2);
  assign in_ready = !(pend1 || pend2) || drains;
  assign accept   = in_valid && in_ready;

  assign col_masked = in_cells & mask;

  // Next map position, history and window contents.
  always_comb begin
    held_next      = held;
    prev_col_next  = prev_col;
    older_col_next = older_col;
    w0_next        = w0;
    w1_next        = w1;
    w2_next        = w2;
    pend1_next     = pend1;
    pend2_next     = pend2;

    // A result leaving the stage without a new transfer.
    if (take) begin
      if (pend1) begin
        pend1_next = 1'b0;
      end else begin
        pend2_next = 1'b0;
      end
    end

    if (accept) begin
      case (held)
        cms_pkg::HELD_NONE: begin
          w0_next    = WALL;
          w1_next    = WALL;
          w2_next    = col_masked | ~mask;
          pend1_next = 1'b0;
          if (in_last) begin
            // A single-column map has wall on both sides.
            pend2_next     = 1'b1;
            prev_col_next  = '0;
            older_col_next = '0;
          end else begin
            pend2_next     = 1'b0;
            prev_col_next  = col_masked;
            older_col_next = '0;
            held_next      = cms_pkg::HELD_ONE;
          end
        end
        cms_pkg::HELD_ONE, cms_pkg::HELD_MANY: begin
          w0_next    = (held == cms_pkg::HELD_ONE) ? WALL : ((older_col & mask) | ~mask);
          w1_next    = (prev_col & mask) | ~mask;
          w2_next    = col_masked | ~mask;
          pend1_next = 1'b1;
          pend2_next = in_last;
          if (in_last) begin
            prev_col_next  = '0;
            older_col_next = '0;
            held_next      = cms_pkg::HELD_NONE;
          end else begin
            older_col_next = prev_col & mask;
            prev_col_next  = col_masked;
            held_next      = cms_pkg::HELD_MANY;
          end
        end
        default: begin
          held_next = cms_pkg::HELD_NONE;
        end
      endcase
    end
  end

  // Control state and history.
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= cms_pkg::HELD_NONE;
      prev_col  <= '0;
      older_col <= '0;
      pend1     <= 1'b0;
      pend2     <= 1'b0;
    end else begin
      held      <= held_next;
      prev_col  <= prev_col_next;
      older_col <= older_col_next;
      pend1     <= pend1_next;
      pend2     <= pend2_next;
    end
  end

  // Window payload needs no reset.
  always_ff @(posedge clk) begin
    w0 <= w0_next;
    w1 <= w1_next;
    w2 <= w2_next;
  end

  // The first pending result uses the leading three columns, the second the trailing three.
  assign win_left  = pend1 ? w0 : w1;
  assign win_mid   = pend1 ? w1 : w2;
  assign win_right = pend1 ? w2 : WALL;

  assign status.valid       = pend1 || pend2;
  assign status.last_of_run = pend1 ? !pend2 : 1'b1;
  assign status.end_of_map  = !pend1;

endmodule
